[rtl/mctc_pkg.sv]
// Package for the match/capture timer counter.
// Beat types, mode and register address codes, control bit positions.
// No dependencies.
package mctc_pkg;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  reg_addr;
		logic [31:0] write_data;
		logic        capture_level;
	} item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq;
		logic        running;
	} result_t;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [3:0] ADDR_FLAGS    = 4'd0;
	localparam logic [3:0] ADDR_CONTROL  = 4'd1;
	localparam logic [3:0] ADDR_COUNT    = 4'd2;
	localparam logic [3:0] ADDR_PRESCALE = 4'd3;
	localparam logic [3:0] ADDR_PRE_CNT  = 4'd4;
	localparam logic [3:0] ADDR_MATCH_CT = 4'd5;
	localparam logic [3:0] ADDR_MATCH    = 4'd6;
	localparam logic [3:0] ADDR_CAP_CT   = 4'd7;
	localparam logic [3:0] ADDR_CAPTURE  = 4'd8;

	// run control bits
	localparam int RUN_ENABLE = 0;
	localparam int RUN_RESET  = 1;
	// match control bits
	localparam int MATCH_FLAG_EN = 0;
	localparam int MATCH_RESTART = 1;
	localparam int MATCH_STOP    = 2;
	// capture control bits
	localparam int CAP_RISE    = 0;
	localparam int CAP_FALL    = 1;
	localparam int CAP_FLAG_EN = 2;
	// flag bits
	localparam int FLAG_MATCH   = 0;
	localparam int FLAG_CAPTURE = 4;

endpackage

[rtl/mctc_timer.sv]
// Timer state registers and single-pass next-state logic for one beat.
// Produces the result beat of the accepted item. Uses mctc_pkg.
module mctc_timer #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  mctc_pkg::item_t  item,
	output mctc_pkg::result_t result
);

	localparam int CW = COUNT_WIDTH;

	logic [CW-1:0] count_q, match_q, capture_q;
	logic [31:0]   pre_cnt_q, pre_lim_q;
	logic [2:0]    match_ctl_q, cap_ctl_q;
	logic [1:0]    run_q;
	logic [4:0]    flags_q;
	logic          last_level_q;

	logic [CW-1:0] count_d, capture_d, count_inc;
	logic [31:0]   pre_cnt_d, pre_lim_d;
	logic [CW-1:0] match_d;
	logic [2:0]    match_ctl_d, cap_ctl_d;
	logic [1:0]    run_d;
	logic [4:0]    flags_d;
	logic          last_level_d;
	logic          rise, fall;
	logic [31:0]   rd;

	assign rise      = item.capture_level && !last_level_q;
	assign fall      = !item.capture_level && last_level_q;
	assign count_inc = count_q + CW'(1);

	always_comb begin
		count_d      = count_q;
		capture_d    = capture_q;
		pre_cnt_d    = pre_cnt_q;
		pre_lim_d    = pre_lim_q;
		match_d      = match_q;
		match_ctl_d  = match_ctl_q;
		cap_ctl_d    = cap_ctl_q;
		run_d        = run_q;
		flags_d      = flags_q;
		last_level_d = last_level_q;
		rd           = '0;
		unique case (item.mode)
			mctc_pkg::MODE_TICK: begin
				// capture sees the count from before this tick
				if ((rise && cap_ctl_q[mctc_pkg::CAP_RISE]) ||
				    (fall && cap_ctl_q[mctc_pkg::CAP_FALL])) begin
					capture_d = count_q;
					if (cap_ctl_q[mctc_pkg::CAP_FLAG_EN])
						flags_d[mctc_pkg::FLAG_CAPTURE] = 1'b1;
				end
				last_level_d = item.capture_level;
				if (run_q[mctc_pkg::RUN_RESET]) begin
					count_d   = '0;
					pre_cnt_d = '0;
				end else if (run_q[mctc_pkg::RUN_ENABLE]) begin
					if (pre_cnt_q != pre_lim_q) begin
						pre_cnt_d = pre_cnt_q + 32'd1;
					end else begin
						pre_cnt_d = '0;
						count_d   = count_inc;
						if (count_inc == match_q) begin
							if (match_ctl_q[mctc_pkg::MATCH_FLAG_EN])
								flags_d[mctc_pkg::FLAG_MATCH] = 1'b1;
							if (match_ctl_q[mctc_pkg::MATCH_RESTART])
								count_d = '0;
							if (match_ctl_q[mctc_pkg::MATCH_STOP])
								run_d[mctc_pkg::RUN_ENABLE] = 1'b0;
						end
					end
				end
			end
			mctc_pkg::MODE_WRITE: begin
				unique case (item.reg_addr)
					mctc_pkg::ADDR_FLAGS:    flags_d = flags_q & ~item.write_data[4:0];
					mctc_pkg::ADDR_CONTROL: begin
						run_d = item.write_data[1:0];
						if (item.write_data[mctc_pkg::RUN_RESET]) begin
							count_d   = '0;
							pre_cnt_d = '0;
						end
					end
					mctc_pkg::ADDR_COUNT:    count_d     = item.write_data[CW-1:0];
					mctc_pkg::ADDR_PRESCALE: pre_lim_d   = item.write_data;
					mctc_pkg::ADDR_PRE_CNT:  pre_cnt_d   = item.write_data;
					mctc_pkg::ADDR_MATCH_CT: match_ctl_d = item.write_data[2:0];
					mctc_pkg::ADDR_MATCH:    match_d     = item.write_data[CW-1:0];
					mctc_pkg::ADDR_CAP_CT:   cap_ctl_d   = item.write_data[2:0];
					default: ; // captured value is read only; unused addresses ignored
				endcase
			end
			mctc_pkg::MODE_READ: begin
				unique case (item.reg_addr)
					mctc_pkg::ADDR_FLAGS:    rd = 32'(flags_q);
					mctc_pkg::ADDR_CONTROL:  rd = 32'(run_q);
					mctc_pkg::ADDR_COUNT:    rd = 32'(count_q);
					mctc_pkg::ADDR_PRESCALE: rd = pre_lim_q;
					mctc_pkg::ADDR_PRE_CNT:  rd = pre_cnt_q;
					mctc_pkg::ADDR_MATCH_CT: rd = 32'(match_ctl_q);
					mctc_pkg::ADDR_MATCH:    rd = 32'(match_q);
					mctc_pkg::ADDR_CAP_CT:   rd = 32'(cap_ctl_q);
					mctc_pkg::ADDR_CAPTURE:  rd = 32'(capture_q);
					default:                 rd = '0;
				endcase
			end
			default: ;
		endcase
	end

	assign result.read_data = rd;
	assign result.irq       = |flags_d;
	assign result.running   = run_d[mctc_pkg::RUN_ENABLE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			capture_q    <= '0;
			pre_cnt_q    <= '0;
			pre_lim_q    <= '0;
			match_q      <= '0;
			match_ctl_q  <= '0;
			cap_ctl_q    <= '0;
			run_q        <= '0;
			flags_q      <= '0;
			last_level_q <= 1'b0;
		end else if (accept) begin
			count_q      <= count_d;
			capture_q    <= capture_d;
			pre_cnt_q    <= pre_cnt_d;
			pre_lim_q    <= pre_lim_d;
			match_q      <= match_d;
			match_ctl_q  <= match_ctl_d;
			cap_ctl_q    <= cap_ctl_d;
			run_q        <= run_d;
			flags_q      <= flags_d;
			last_level_q <= last_level_d;
		end
	end

endmodule

[rtl/mctc_out_buf.sv]
// Result register with a skid stage behind it.
// Lets a new beat in while a finished result waits. Uses mctc_pkg.
module mctc_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  mctc_pkg::result_t load_data,
	output logic              full,
	output logic              result_valid,
	input  logic              result_stall,
	output mctc_pkg::result_t result
);

	logic              res_v_q, skid_v_q;
	mctc_pkg::result_t res_q, skid_q;
	logic              take;

	assign take         = res_v_q && !result_stall;
	assign full         = skid_v_q;
	assign result_valid = res_v_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!res_v_q || take) begin
			// skid beat first; no load can happen while it is occupied
			res_v_q  <= skid_v_q || load;
			skid_v_q <= 1'b0;
		end else if (load) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!res_v_q || take) begin
			res_q <= skid_v_q ? skid_q : load_data;
		end else if (load) begin
			skid_q <= load_data;
		end
	end

endmodule

[rtl/match_capture_timer_counter_core.sv]
// Match/capture timer counter, top level.
// An accepted item's result beat reaches the output in the next cycle when the output is free.
// Throughput: one item per cycle unless stalled; all work sits between state and result registers.
// A two-deep output (result register plus skid) raises item_stall only when both are full.
// arst_n clears all timer state and empties the output at once.
// Instantiates mctc_timer and mctc_out_buf; uses mctc_pkg.
module match_capture_timer_counter_core #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  mctc_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output mctc_pkg::result_t result
);

	logic              accept;
	mctc_pkg::result_t next_result;

	assign accept = item_valid && !item_stall;

	mctc_timer #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_timer (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.item  (item),
		.result(next_result)
	);

	mctc_out_buf u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.load_data   (next_result),
		.full        (item_stall),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

[rtl/mctc_checker.sv]
// Port-level checker for the match/capture timer counter, with its bind.
// Sees the top-level ports only. Uses mctc_pkg.
module mctc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input mctc_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_stall,
	input mctc_pkg::result_t result
);

	// a held result beat keeps its value
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// a beat taken into an empty output shows up on the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && !result_valid |=> result_valid)
		else $error("accepted beat did not reach the output");

	// input stalls only with a result waiting
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("stall without a pending result");

	a_stall_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(item_stall) |-> $past(result_valid && result_stall && item_valid))
		else $error("stall raised without a blocked output");

	// flops may be unknown before the first reset edge, so the check is made at the following clock edge
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !result_valid && !item_stall)
		else $error("output not empty in reset");

endmodule

bind match_capture_timer_counter_core mctc_checker u_mctc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_stall  (item_stall),
	.item        (item),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result      (result)
);

[tb/tb.sv]
// Self-checking testbench for match_capture_timer_counter_core.
// Drives tick/read/write beats, predicts each result in a local timer model, checks every field.
// Depends on mctc_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb;

	localparam int CW          = 32;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 60;
	localparam int MAX_REPORTS = 20;

	localparam logic [1:0] MODE_UNUSED   = 2'd3;
	localparam logic [3:0] ADDR_SPARE_LO = 4'd9;
	localparam logic [3:0] ADDR_SPARE_HI = 4'd15;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_stall;
	mctc_pkg::item_t   item         = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	mctc_pkg::result_t result;

	mctc_pkg::item_t   items_to_send[$];
	mctc_pkg::result_t results_due[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_len = 0;
	int hold_done = 0;
	int idle_cycles = 0;
	int fails = 0;

	// timer model state
	logic [CW-1:0] cnt, match_val, cap_val;
	logic [31:0]   pre_cnt, pre_lim;
	logic [2:0]    match_ctl, cap_ctl;
	logic [1:0]    run_ctl;
	logic [4:0]    flags;
	logic          cap_last;

	match_capture_timer_counter_core #(.COUNT_WIDTH(CW)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic timer_reset();
		cnt = '0;
		match_val = '0;
		cap_val = '0;
		pre_cnt = '0;
		pre_lim = '0;
		match_ctl = '0;
		cap_ctl = '0;
		run_ctl = '0;
		flags = '0;
		cap_last = 1'b0;
	endtask

	// Advance the timer model by one beat and return the result it produces.
	task automatic timer_step(input mctc_pkg::item_t it, output mctc_pkg::result_t r);
		logic [31:0] rd;
		logic rise, fall;
		rd = '0;
		case (it.mode)
			mctc_pkg::MODE_TICK: begin
				rise = it.capture_level && !cap_last;
				fall = !it.capture_level && cap_last;
				// capture sees the count from before this tick, even when stopped
				if ((rise && cap_ctl[mctc_pkg::CAP_RISE]) ||
				    (fall && cap_ctl[mctc_pkg::CAP_FALL])) begin
					cap_val = cnt;
					if (cap_ctl[mctc_pkg::CAP_FLAG_EN])
						flags[mctc_pkg::FLAG_CAPTURE] = 1'b1;
				end
				cap_last = it.capture_level;
				if (run_ctl[mctc_pkg::RUN_RESET]) begin
					cnt = '0;
					pre_cnt = '0;
				end else if (run_ctl[mctc_pkg::RUN_ENABLE]) begin
					if (pre_cnt != pre_lim) begin
						pre_cnt = pre_cnt + 32'd1;
					end else begin
						pre_cnt = '0;
						cnt = cnt + 1'b1;
						if (cnt == match_val) begin
							if (match_ctl[mctc_pkg::MATCH_FLAG_EN])
								flags[mctc_pkg::FLAG_MATCH] = 1'b1;
							if (match_ctl[mctc_pkg::MATCH_RESTART])
								cnt = '0;
							if (match_ctl[mctc_pkg::MATCH_STOP])
								run_ctl[mctc_pkg::RUN_ENABLE] = 1'b0;
						end
					end
				end
			end
			mctc_pkg::MODE_WRITE: begin
				case (it.reg_addr)
					mctc_pkg::ADDR_FLAGS:    flags = flags & ~it.write_data[4:0];
					mctc_pkg::ADDR_CONTROL: begin
						run_ctl = it.write_data[1:0];
						if (run_ctl[mctc_pkg::RUN_RESET]) begin
							cnt = '0;
							pre_cnt = '0;
						end
					end
					mctc_pkg::ADDR_COUNT:    cnt = it.write_data[CW-1:0];
					mctc_pkg::ADDR_PRESCALE: pre_lim = it.write_data;
					mctc_pkg::ADDR_PRE_CNT:  pre_cnt = it.write_data;
					mctc_pkg::ADDR_MATCH_CT: match_ctl = it.write_data[2:0];
					mctc_pkg::ADDR_MATCH:    match_val = it.write_data[CW-1:0];
					mctc_pkg::ADDR_CAP_CT:   cap_ctl = it.write_data[2:0];
					default: ;
				endcase
			end
			mctc_pkg::MODE_READ: begin
				case (it.reg_addr)
					mctc_pkg::ADDR_FLAGS:    rd = 32'(flags);
					mctc_pkg::ADDR_CONTROL:  rd = 32'(run_ctl);
					mctc_pkg::ADDR_COUNT:    rd = 32'(cnt);
					mctc_pkg::ADDR_PRESCALE: rd = pre_lim;
					mctc_pkg::ADDR_PRE_CNT:  rd = pre_cnt;
					mctc_pkg::ADDR_MATCH_CT: rd = 32'(match_ctl);
					mctc_pkg::ADDR_MATCH:    rd = 32'(match_val);
					mctc_pkg::ADDR_CAP_CT:   rd = 32'(cap_ctl);
					mctc_pkg::ADDR_CAPTURE:  rd = 32'(cap_val);
					default: ;
				endcase
			end
			default: ;
		endcase
		r.read_data = rd;
		r.irq = |flags;
		r.running = run_ctl[mctc_pkg::RUN_ENABLE];
	endtask

	task automatic push_beat(input logic [1:0] m, input logic [3:0] a, input logic [31:0] d,
			input logic lvl);
		mctc_pkg::item_t it;
		it.mode = m;
		it.reg_addr = a;
		it.write_data = d;
		it.capture_level = lvl;
		items_to_send.push_back(it);
	endtask

	task automatic push_tick(input logic lvl);
		push_beat(mctc_pkg::MODE_TICK, '0, $urandom(), lvl);
	endtask

	task automatic push_wr(input logic [3:0] a, input logic [31:0] d);
		push_beat(mctc_pkg::MODE_WRITE, a, d, 1'($urandom_range(0, 1)));
	endtask

	task automatic push_rd(input logic [3:0] a);
		push_beat(mctc_pkg::MODE_READ, a, $urandom(), 1'($urandom_range(0, 1)));
	endtask

	// Short counting scenarios with small prescale and match values and frequent ticks so that
	// matches, restarts, stops and captures keep happening; the rest is noise.
	task automatic queue_random(input int n);
		int made, k;
		logic [3:0] a;
		made = 0;
		while (made < n) begin
			k = $urandom_range(0, 99);
			a = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 8));
			if (k < 10) begin
				push_wr(mctc_pkg::ADDR_PRESCALE, $urandom_range(0, 3));
				push_wr(mctc_pkg::ADDR_COUNT, $urandom_range(0, 8));
				push_wr(mctc_pkg::ADDR_MATCH, $urandom_range(0, 24));
				push_wr(mctc_pkg::ADDR_MATCH_CT, $urandom_range(0, 7));
				push_wr(mctc_pkg::ADDR_CAP_CT, $urandom_range(0, 7));
				push_wr(mctc_pkg::ADDR_CONTROL, 32'd1 << mctc_pkg::RUN_ENABLE);
				made += 6;
			end else if (k < 60) begin
				push_tick(1'($urandom_range(0, 1)));
				made++;
			end else if (k < 72) begin
				push_rd(a);
				made++;
			end else if (k < 76) begin
				push_wr(mctc_pkg::ADDR_FLAGS, $urandom());
				made++;
			end else if (k < 94) begin
				push_wr(a, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 15));
				made++;
			end else if (k < 97) begin
				push_wr(mctc_pkg::ADDR_CONTROL, $urandom_range(0, 3));
				made++;
			end else begin
				push_beat(MODE_UNUSED, 4'($urandom_range(0, 15)), $urandom(),
					1'($urandom_range(0, 1)));
				made++;
			end
		end
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (items_to_send.size() != 0 || item_valid || results_due.size() != 0);
	endtask

	function automatic void check_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			fails++;
			if (fails <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h actual %h", $time, fname, want, got);
		end
	endfunction

	// driver: predicts each accepted beat and offers the next one
	always @(posedge clk) begin
		mctc_pkg::result_t r;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				timer_step(item, r);
				results_due.push_back(r);
			end
			if (!item_valid || !item_stall) begin
				if (items_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					item <= items_to_send.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks result beats and drives stall
	always @(posedge clk) begin
		mctc_pkg::result_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (results_due.size() == 0) begin
					fails++;
					if (fails <= MAX_REPORTS)
						$display("%0t: unexpected result beat, expected none actual %h", $time,
							result);
				end else begin
					want = results_due.pop_front();
					check_field("read_data", want.read_data, result.read_data);
					check_field("irq", 32'(want.irq), 32'(result.irq));
					check_field("running", 32'(want.running), 32'(result.running));
				end
			end
			if (hold_done < hold_len) begin
				result_stall <= 1'b1;
				hold_done <= hold_done + 1;
			end else begin
				result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		timer_reset();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: capture while stopped, flag clearing, wrap into a match of zero
		// with flag/restart/stop, prescale count above its limit, reset hold, spares
		push_wr(mctc_pkg::ADDR_CAP_CT, 32'd7);
		push_tick(1'b1);
		push_rd(mctc_pkg::ADDR_FLAGS);
		push_wr(mctc_pkg::ADDR_FLAGS, 32'hFFFF_FFE0);
		push_wr(mctc_pkg::ADDR_FLAGS, 32'hFFFF_FFFF);
		push_wr(mctc_pkg::ADDR_COUNT, 32'hFFFF_FFFF);
		push_wr(mctc_pkg::ADDR_MATCH, 32'h0);
		push_wr(mctc_pkg::ADDR_MATCH_CT, 32'd7);
		push_wr(mctc_pkg::ADDR_CONTROL, 32'd1 << mctc_pkg::RUN_ENABLE);
		push_tick(1'b0);
		push_rd(mctc_pkg::ADDR_CAPTURE);
		push_rd(mctc_pkg::ADDR_CONTROL);
		push_wr(mctc_pkg::ADDR_CAPTURE, 32'h1234_5678);
		push_wr(mctc_pkg::ADDR_PRE_CNT, 32'hFFFF_FFFF);
		push_wr(mctc_pkg::ADDR_CONTROL, 32'd1 << mctc_pkg::RUN_ENABLE);
		push_tick(1'b1);
		push_tick(1'b0);
		push_rd(mctc_pkg::ADDR_PRE_CNT);
		push_wr(mctc_pkg::ADDR_CONTROL,
			(32'd1 << mctc_pkg::RUN_ENABLE) | (32'd1 << mctc_pkg::RUN_RESET));
		push_tick(1'b1);
		push_rd(mctc_pkg::ADDR_COUNT);
		push_wr(ADDR_SPARE_HI, 32'hFFFF_FFFF);
		push_rd(ADDR_SPARE_LO);
		push_beat(MODE_UNUSED, ADDR_SPARE_HI, 32'hFFFF_FFFF, 1'b1);
		push_wr(mctc_pkg::ADDR_PRESCALE, 32'hFFFF_FFFF);
		push_rd(mctc_pkg::ADDR_PRESCALE);
		queue_random(110);
		drain();

		send_idle_pct = 68;
		queue_random(110);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 68;
		queue_random(110);
		drain();

		send_idle_pct = 38;
		recv_stall_pct = 38;
		queue_random(110);
		drain();

		// long receiver hold-off while the sender keeps offering beats
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_len = HOLD_CYCLES;
		queue_random(50);
		drain();

		repeat (10) @(negedge clk);
		if (fails == 0 && results_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
